// ===== rtl/cflpa_pkg.sv =====
`timescale 1ns / 1ps
package cflpa_pkg;

  localparam int MAX_CHUNKS      = 16;
  localparam int SLOTS_PER_CHUNK = 255;
  localparam int CHUNK_W         = 4;
  localparam int SLOT_W          = 8;
  localparam int OPEN_W          = $clog2(MAX_CHUNKS + 1);
  localparam int LINK_AW         = CHUNK_W + SLOT_W;
  localparam int LINK_DEPTH      = MAX_CHUNKS * (2 ** SLOT_W);
  localparam int BB_W            = 16;
  localparam int OFS_W           = 24;
  localparam logic [BB_W-1:0] BB_RESET = 16'd16;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC     = 2'd0;
  localparam logic [1:0] ST_FREED     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BADFREE   = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_OPEN   = 6'b000100,
    S_POP_RD = 6'b001000,
    S_POP_WB = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic set_exh;
    logic set_bad;
    logic do_free;
    logic take;
    logic start_open;
    logic sweep;
    logic open_done;
    logic pop_rd;
    logic pop_wb;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic free_bad;
    logic exhausted;
    logic need_open;
    logic sweep_last;
  } sts_t;

endpackage

// ===== rtl/cflpa_ram.sv =====
`timescale 1ns / 1ps
module cflpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cflpa_ctrl.sv =====
`timescale 1ns / 1ps
module cflpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cflpa_pkg::sts_t sts,
  output cflpa_pkg::cmd_t cmd,
  output logic            done
);

  cflpa_pkg::state_t state, state_next;

  assign busy = (state != cflpa_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      cflpa_pkg::S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = cflpa_pkg::S_DECIDE;
        end
      end
      cflpa_pkg::S_DECIDE: begin
        if (sts.is_free) begin
          if (sts.free_bad) begin
            cmd.set_bad = 1'b1;
          end else begin
            cmd.do_free = 1'b1;
          end
          state_next = cflpa_pkg::S_FIN;
        end else if (sts.exhausted) begin
          cmd.set_exh = 1'b1;
          state_next  = cflpa_pkg::S_FIN;
        end else if (sts.need_open) begin
          cmd.start_open = 1'b1;
          state_next     = cflpa_pkg::S_OPEN;
        end else begin
          cmd.take   = 1'b1;
          state_next = cflpa_pkg::S_POP_RD;
        end
      end
      cflpa_pkg::S_OPEN: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.open_done = 1'b1;
          state_next    = cflpa_pkg::S_POP_RD;
        end
      end
      cflpa_pkg::S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_next = cflpa_pkg::S_POP_WB;
      end
      cflpa_pkg::S_POP_WB: begin
        cmd.pop_wb = 1'b1;
        state_next = cflpa_pkg::S_FIN;
      end
      cflpa_pkg::S_FIN: begin
        cmd.finish = 1'b1;
        state_next = cflpa_pkg::S_IDLE;
      end
      default: begin
        state_next = cflpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cflpa_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == cflpa_pkg::S_FIN))
    else $error("strobe without finish");
  a_open_holds: assert property (@(posedge clk) disable iff (rst)
    (state == cflpa_pkg::S_OPEN && !sts.sweep_last) |=> (state == cflpa_pkg::S_OPEN))
    else $error("chunk init sweep cut short");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("strobe while busy");

endmodule

// ===== rtl/cflpa_dp.sv =====
`timescale 1ns / 1ps
module cflpa_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cflpa_pkg::cmd_t                      cmd,
  output cflpa_pkg::sts_t                      sts,
  input  logic                                 req_type,
  input  logic [cflpa_pkg::CHUNK_W-1:0]        free_chunk,
  input  logic [cflpa_pkg::SLOT_W-1:0]         free_slot,
  input  logic                                 cfg_valid,
  input  logic [cflpa_pkg::BB_W-1:0]           cfg_data,
  output logic [1:0]                           status,
  output logic [cflpa_pkg::CHUNK_W-1:0]        chunk_index,
  output logic [cflpa_pkg::SLOT_W-1:0]         slot_index,
  output logic [cflpa_pkg::OFS_W-1:0]          chunk_offset,
  output logic [cflpa_pkg::SLOT_W-1:0]         free_in_chunk
);

  localparam logic [cflpa_pkg::SLOT_W-1:0] LAST_SLOT =
    cflpa_pkg::SLOT_W'(cflpa_pkg::SLOTS_PER_CHUNK - 1);
  localparam logic [cflpa_pkg::SLOT_W-1:0] FULL_CNT =
    cflpa_pkg::SLOT_W'(cflpa_pkg::SLOTS_PER_CHUNK);

  logic [cflpa_pkg::BB_W-1:0]    block_bytes;
  logic                          req;
  logic [cflpa_pkg::SLOT_W-1:0]  fslot;
  logic [cflpa_pkg::CHUNK_W-1:0] cidx;
  logic [cflpa_pkg::SLOT_W-1:0]  list_head [cflpa_pkg::MAX_CHUNKS];
  logic [cflpa_pkg::SLOT_W-1:0]  free_count [cflpa_pkg::MAX_CHUNKS];
  logic [cflpa_pkg::OPEN_W-1:0]  chunks_open;
  logic [cflpa_pkg::CHUNK_W-1:0] alloc_chunk, freed_chunk;
  logic                          alloc_valid, freed_valid;
  logic [cflpa_pkg::SLOT_W-1:0]  sweep_cnt;

  logic [cflpa_pkg::MAX_CHUNKS-1:0] room;
  logic                             alloc_hit, freed_hit, found, can_open;
  logic [cflpa_pkg::CHUNK_W-1:0]    search_idx, choice;
  logic [cflpa_pkg::SLOT_W-1:0]     cur_head, cur_cnt, pop_slot;

  logic                             ram_we;
  logic [cflpa_pkg::LINK_AW-1:0]    ram_waddr;
  logic [cflpa_pkg::SLOT_W-1:0]     ram_wdata, ram_rdata;

  always_comb begin
    for (int i = 0; i < cflpa_pkg::MAX_CHUNKS; i++) begin
      room[i] = (free_count[i] != '0) && (cflpa_pkg::OPEN_W'(i) < chunks_open);
    end
    found      = 1'b0;
    search_idx = '0;
    for (int i = cflpa_pkg::MAX_CHUNKS - 1; i >= 0; i--) begin
      if (room[i]) begin
        found      = 1'b1;
        search_idx = cflpa_pkg::CHUNK_W'(i);
      end
    end
  end

  assign alloc_hit = alloc_valid && room[alloc_chunk];
  assign freed_hit = freed_valid && room[freed_chunk];
  assign can_open  = chunks_open < cflpa_pkg::OPEN_W'(cflpa_pkg::MAX_CHUNKS);
  assign choice    = alloc_hit ? alloc_chunk : (freed_hit ? freed_chunk : search_idx);

  assign cur_head = list_head[cidx];
  assign cur_cnt  = free_count[cidx];
  assign pop_slot = (cur_head >= FULL_CNT) ? '0 : cur_head;

  assign sts.is_free    = (req == cflpa_pkg::REQ_FREE);
  assign sts.free_bad   = (cflpa_pkg::OPEN_W'(cidx) >= chunks_open) ||
                          (fslot >= FULL_CNT) || (cur_cnt >= FULL_CNT);
  assign sts.exhausted  = !alloc_hit && !freed_hit && !found && !can_open;
  assign sts.need_open  = !alloc_hit && !freed_hit && !found && can_open;
  assign sts.sweep_last = (sweep_cnt == LAST_SLOT);

  // link writes: chunk init sweep, or push on free
  always_comb begin
    ram_we    = cmd.sweep || cmd.do_free;
    ram_waddr = cmd.sweep ? {cidx, sweep_cnt} : {cidx, fslot};
    ram_wdata = cmd.sweep ? ((sweep_cnt == LAST_SLOT) ? '0 : sweep_cnt + 1'b1)
                          : cur_head;
  end

  cflpa_ram #(
    .WIDTH (cflpa_pkg::SLOT_W),
    .DEPTH (cflpa_pkg::LINK_DEPTH)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.pop_rd),
    .raddr ({cidx, pop_slot}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= cflpa_pkg::BB_RESET;
      chunks_open <= '0;
      alloc_valid <= 1'b0;
      freed_valid <= 1'b0;
      for (int i = 0; i < cflpa_pkg::MAX_CHUNKS; i++) begin
        list_head[i]  <= '0;
        free_count[i] <= FULL_CNT;
      end
    end else begin
      if (cfg_valid) begin
        block_bytes <= cfg_data;
      end
      if (cmd.take) begin
        alloc_chunk <= choice;
        alloc_valid <= 1'b1;
      end
      if (cmd.do_free) begin
        list_head[cidx]  <= fslot;
        free_count[cidx] <= cur_cnt + 1'b1;
        freed_chunk      <= cidx;
        freed_valid      <= 1'b1;
      end
      if (cmd.open_done) begin
        list_head[cidx]  <= '0;
        free_count[cidx] <= FULL_CNT;
        chunks_open      <= chunks_open + 1'b1;
        alloc_chunk      <= cidx;
        alloc_valid      <= 1'b1;
        freed_chunk      <= cidx;
        freed_valid      <= 1'b1;
      end
      if (cmd.pop_wb) begin
        list_head[cidx]  <= ram_rdata;
        free_count[cidx] <= cur_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= req_type;
      fslot <= free_slot;
      cidx  <= free_chunk;
    end
    if (cmd.take) begin
      cidx <= choice;
    end
    if (cmd.start_open) begin
      cidx      <= chunks_open[cflpa_pkg::CHUNK_W-1:0];
      sweep_cnt <= '0;
    end
    if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
    if (cmd.set_exh || cmd.set_bad) begin
      status        <= cmd.set_exh ? cflpa_pkg::ST_EXHAUSTED : cflpa_pkg::ST_BADFREE;
      chunk_index   <= '0;
      slot_index    <= '0;
      free_in_chunk <= '0;
    end
    if (cmd.do_free) begin
      status        <= cflpa_pkg::ST_FREED;
      chunk_index   <= cidx;
      slot_index    <= fslot;
      free_in_chunk <= cur_cnt + 1'b1;
    end
    if (cmd.pop_rd) begin
      chunk_index <= cidx;
      slot_index  <= pop_slot;
    end
    if (cmd.pop_wb) begin
      status        <= cflpa_pkg::ST_ALLOC;
      free_in_chunk <= cur_cnt - 1'b1;
    end
    if (cmd.finish) begin
      chunk_offset <= cflpa_pkg::OFS_W'(cflpa_pkg::OFS_W'(slot_index) *
                                        cflpa_pkg::OFS_W'(block_bytes));
    end
  end

endmodule

// ===== rtl/chunked_free_list_pool_allocator.sv =====
`timescale 1ns / 1ps
// channel   signals                                          dir   handshake
// request   req_type free_chunk free_slot                    in    start & !busy
// result    status chunk_index slot_index chunk_offset       out   done, one cycle
//           free_in_chunk
// config    cfg_data (block_bytes)                           in    cfg_valid & cfg_ready
//
// Alloc from an open chunk: DECIDE, POP_RD, POP_WB, FIN; free or a failed request: DECIDE, FIN.
// Opening a chunk first sweeps its 255 link words, one per cycle.
// Registered link RAM read then head update sets the alloc path length.
// rst is synchronous: no chunks open, block_bytes = 16. Link RAM is not cleared.
// Results cannot be stalled; cfg_ready is always high.
module chunked_free_list_pool_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type,
  input  logic [cflpa_pkg::CHUNK_W-1:0]        free_chunk,
  input  logic [cflpa_pkg::SLOT_W-1:0]         free_slot,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cflpa_pkg::BB_W-1:0]           cfg_data,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [cflpa_pkg::CHUNK_W-1:0]        chunk_index,
  output logic [cflpa_pkg::SLOT_W-1:0]         slot_index,
  output logic [cflpa_pkg::OFS_W-1:0]          chunk_offset,
  output logic [cflpa_pkg::SLOT_W-1:0]         free_in_chunk
);

  cflpa_pkg::cmd_t cmd;
  cflpa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cflpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd),
    .done  (done)
  );

  cflpa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .free_chunk    (free_chunk),
    .free_slot     (free_slot),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .status        (status),
    .chunk_index   (chunk_index),
    .slot_index    (slot_index),
    .chunk_offset  (chunk_offset),
    .free_in_chunk (free_in_chunk)
  );

endmodule
